/* src/mbps_pkg.sv */
// Shared types and constants for the masked byte pattern search block.
// No dependencies; used by mbps_match and masked_byte_pattern_search.
package mbps_pkg;

  localparam int PATTERN_MAX  = 16;
  localparam int OFFSET_WIDTH = 32;

  // Stored history bytes; at least one entry so the window keeps a legal range.
  localparam int WINDOW_DEPTH = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
  localparam int LEN_W        = $clog2(PATTERN_MAX + 1);
  localparam int DIST_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  localparam int CFG_DATA_W   = 64;
  localparam int CFG_INDEX_W  = 2;
  localparam int LEN_REG_W    = 5;
  localparam int CARE_REG_W   = 16;
  localparam int RESULT_OFF_W = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_LOW  = 2'd0,
    CFG_PATTERN_HIGH = 2'd1,
    CFG_CARE_MASK    = 2'd2,
    CFG_PATTERN_LEN  = 2'd3
  } cfg_idx_e;

  // Pattern setup as seen by the compare logic; length already clamped.
  typedef struct packed {
    logic [PATTERN_MAX-1:0][7:0] pattern;
    logic [PATTERN_MAX-1:0]      care;
    logic [LEN_W-1:0]            len;
  } pat_cfg_t;

  typedef logic [WINDOW_DEPTH-1:0][7:0] window_t;

endpackage

/* src/masked_byte_pattern_search.sv */
// Masked byte pattern search, top level: config registers, input stage,
// scan state and result register. Depends on mbps_pkg and mbps_match.
//
// Streams a buffer in one byte per cycle and, on the byte flagged last,
// returns one item: whether the configured pattern (up to 16 bytes, each
// with a care bit; a clear bit is a wildcard) occurred, and the offset of the
// earliest match. A zero pattern length matches at offset 0; a buffer shorter
// than the pattern reports not found. The byte position saturates at its
// maximum. Throughput is one byte per clock: the whole window compare sits
// between the input register and the scan state. A result is presented from
// the result register: its last byte passes through the input register,
// then loads the result register once no earlier result is stalled there.
// Input is held off only while a last byte waits behind a stalled result.
// Write configuration only while no buffer is in flight.
module masked_byte_pattern_search (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       data_byte_i,
  input  logic                             last_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             found_o,
  output logic [31:0]                      match_offset_o
);

  localparam logic [mbps_pkg::OFFSET_WIDTH-1:0] PosMax = '1;

  // Configuration registers
  logic [63:0]                       pat_low_q, pat_high_q;
  logic [mbps_pkg::CARE_REG_W-1:0]   care_q;
  logic [mbps_pkg::LEN_REG_W-1:0]    len_q;
  mbps_pkg::pat_cfg_t                pcfg;

  // Input stage
  logic       s1_valid_q, s1_valid_d;
  logic       s1_last_q;
  logic [7:0] s1_byte_q;
  logic       in_accept, s1_go, s1_fire;

  // Scan state
  mbps_pkg::window_t                   window_q;
  logic [mbps_pkg::OFFSET_WIDTH-1:0]   pos_q, pos_d;
  logic                                seen_q, seen_d;
  logic [mbps_pkg::OFFSET_WIDTH-1:0]   off_q, off_d;
  logic                                hit;
  logic [mbps_pkg::OFFSET_WIDTH-1:0]   len_m1;

  // Result register
  logic        out_valid_q, out_valid_d;
  logic        found_q;
  logic [31:0] off_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      care_q     <= '0;
      len_q      <= '0;
    end else if (cfg_we_i) begin
      case (mbps_pkg::cfg_idx_e'(cfg_index_i))
        mbps_pkg::CFG_PATTERN_LOW:  pat_low_q  <= cfg_data_i;
        mbps_pkg::CFG_PATTERN_HIGH: pat_high_q <= cfg_data_i;
        mbps_pkg::CFG_CARE_MASK:    care_q     <= cfg_data_i[mbps_pkg::CARE_REG_W-1:0];
        mbps_pkg::CFG_PATTERN_LEN:  len_q      <= cfg_data_i[mbps_pkg::LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp an overlong length to the pattern size
  always_comb begin
    logic [127:0] pat_all;
    pat_all      = {pat_high_q, pat_low_q};
    pcfg.pattern = pat_all[mbps_pkg::PATTERN_MAX*8-1:0];
    pcfg.care    = care_q[mbps_pkg::PATTERN_MAX-1:0];
    if (len_q > mbps_pkg::LEN_REG_W'(mbps_pkg::PATTERN_MAX)) begin
      pcfg.len = mbps_pkg::LEN_W'(mbps_pkg::PATTERN_MAX);
    end else begin
      pcfg.len = len_q[mbps_pkg::LEN_W-1:0];
    end
  end

  // A last byte may only advance when the result register can take it
  assign s1_go      = !s1_last_q || !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s1_go;
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  mbps_match u_match (
    .cfg_i      (pcfg),
    .cur_byte_i (s1_byte_q),
    .window_i   (window_q),
    .hit_o      (hit)
  );

  assign len_m1 = mbps_pkg::OFFSET_WIDTH'(pcfg.len) - 1'b1;

  always_comb begin
    seen_d = seen_q;
    off_d  = off_q;
    pos_d  = pos_q;
    if (s1_fire) begin
      if (!seen_q) begin
        if (pcfg.len == '0) begin
          seen_d = 1'b1;
          off_d  = '0;
        end else if (pos_q >= len_m1 && hit) begin
          seen_d = 1'b1;
          off_d  = pos_q - len_m1;
        end
      end
      if (pos_q != PosMax) begin
        pos_d = pos_q + 1'b1;
      end
      // drop scan state at the end of a buffer
      if (s1_last_q) begin
        seen_d = 1'b0;
        off_d  = '0;
        pos_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      seen_q <= 1'b0;
      off_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      seen_q <= seen_d;
      off_q  <= off_d;
    end
  end

  // Window entries are only read once the current buffer has written them
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      for (int i = mbps_pkg::WINDOW_DEPTH - 1; i > 0; i--) begin
        window_q[i] <= window_q[i-1];
      end
      window_q[0] <= s1_byte_q;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      found_q <= (!seen_q && pcfg.len == '0) || (!seen_q && pos_q >= len_m1 && hit) || seen_q;
      if (seen_q) begin
        off_out_q <= mbps_pkg::RESULT_OFF_W'(off_q);
      end else if (pcfg.len != '0 && pos_q >= len_m1 && hit) begin
        off_out_q <= mbps_pkg::RESULT_OFF_W'(pos_q - len_m1);
      end else begin
        off_out_q <= '0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_offset_o = off_out_q;

  // Assertions
  a_no_found_zero_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> match_offset_o == '0)
    else $error("offset nonzero without a match");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_last_q |=> pos_q == '0 && !seen_q && off_q == '0)
    else $error("scan state not cleared after last byte");

  a_off_behind_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> off_q <= pos_q)
    else $error("match offset ahead of byte position");

  a_pos_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !s1_last_q && pos_q == PosMax |=> pos_q == PosMax)
    else $error("byte position wrapped");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_last_q && out_valid_q)
    else $error("input held off without a blocked result");

endmodule

/* src/mbps_match.sv */
// Masked window compare: checks the current byte plus the byte history
// against the configured pattern. Depends on mbps_pkg.
module mbps_match (
  input  mbps_pkg::pat_cfg_t cfg_i,
  input  logic [7:0]         cur_byte_i,
  input  mbps_pkg::window_t  window_i,
  output logic               hit_o
);

  logic [mbps_pkg::PATTERN_MAX-1:0][7:0] recent;
  logic [mbps_pkg::PATTERN_MAX-1:0]      mismatch;

  // recent[k] is the byte k positions back; entry 0 is the current byte
  always_comb begin
    recent[0] = cur_byte_i;
    for (int k = 1; k < mbps_pkg::PATTERN_MAX; k++) begin
      recent[k] = window_i[k-1];
    end
  end

  // Pattern byte j lines up with the byte (len - 1 - j) back.
  always_comb begin
    logic [mbps_pkg::DIST_W-1:0] back_idx;
    for (int j = 0; j < mbps_pkg::PATTERN_MAX; j++) begin
      back_idx = mbps_pkg::DIST_W'(int'(cfg_i.len) - 1 - j);
      mismatch[j] = cfg_i.care[j] && (j < int'(cfg_i.len))
                    && (recent[back_idx] != cfg_i.pattern[j]);
    end
  end

  assign hit_o = (mismatch == '0);

endmodule

/* bench/tb_masked_byte_pattern_search.sv */
`timescale 1ns / 100ps
// Testbench for masked_byte_pattern_search: random and directed buffers checked
// against a scoreboard that tracks the byte window and earliest match offset.
// Depends on mbps_pkg and the masked_byte_pattern_search RTL.
module tb_masked_byte_pattern_search;

  // Mirrors the scan state and registers; predicts one result per last byte.
  class scan_scoreboard;
    typedef struct {
      logic                              found;
      logic [mbps_pkg::RESULT_OFF_W-1:0] offset;
    } scan_result_t;

    logic [mbps_pkg::CFG_DATA_W-1:0]   pat_lo;
    logic [mbps_pkg::CFG_DATA_W-1:0]   pat_hi;
    logic [mbps_pkg::CARE_REG_W-1:0]   care;
    logic [mbps_pkg::LEN_REG_W-1:0]    plen;
    logic [7:0]                        history [mbps_pkg::WINDOW_DEPTH];
    logic [mbps_pkg::OFFSET_WIDTH-1:0] pos;
    logic [mbps_pkg::OFFSET_WIDTH-1:0] first_off;
    bit                                seen;
    scan_result_t                      expected_q[$];
    int                                errors;

    function new();
      pat_lo = '0;
      pat_hi = '0;
      care   = '0;
      plen   = '0;
      errors = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      foreach (history[i]) history[i] = 8'h00;
      pos       = '0;
      first_off = '0;
      seen      = 1'b0;
    endfunction

    function void write_reg(mbps_pkg::cfg_idx_e idx, logic [mbps_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        mbps_pkg::CFG_PATTERN_LOW:  pat_lo = value;
        mbps_pkg::CFG_PATTERN_HIGH: pat_hi = value;
        mbps_pkg::CFG_CARE_MASK:    care   = value[mbps_pkg::CARE_REG_W-1:0];
        mbps_pkg::CFG_PATTERN_LEN:  plen   = value[mbps_pkg::LEN_REG_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] cur, logic last);
      int           len;
      int           k;
      logic [7:0]   seen_b;
      logic [7:0]   pat_b;
      bit           hit;
      scan_result_t res;
      len = (plen > mbps_pkg::PATTERN_MAX) ? mbps_pkg::PATTERN_MAX : int'(plen);
      if (!seen) begin
        if (len == 0) begin
          seen      = 1'b1;
          first_off = '0;
        end else if (pos >= mbps_pkg::OFFSET_WIDTH'(len - 1)) begin
          hit = 1'b1;
          for (int j = 0; j < len; j++) begin
            if (care[j]) begin
              k      = len - 1 - j;
              seen_b = (k == 0) ? cur : history[k-1];
              pat_b  = (j < 8) ? pat_lo[8*j +: 8] : pat_hi[8*(j-8) +: 8];
              if (seen_b != pat_b) hit = 1'b0;
            end
          end
          if (hit) begin
            seen      = 1'b1;
            first_off = pos - mbps_pkg::OFFSET_WIDTH'(len - 1);
          end
        end
      end
      for (int i = mbps_pkg::WINDOW_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = cur;
      // saturate at the top of the offset range
      if (pos != '1) pos = pos + 1'b1;
      if (last) begin
        res.found  = seen;
        res.offset = seen ? first_off[mbps_pkg::RESULT_OFF_W-1:0] : '0;
        expected_q.push_back(res);
        clear_scan();
      end
    endfunction

    function void check_result(logic found, logic [mbps_pkg::RESULT_OFF_W-1:0] offset);
      scan_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected: found %0d offset %0d",
                 $time, found, offset);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (found !== exp_r.found) begin
        $display("%0t: found mismatch: expected %0d, actual %0d",
                 $time, exp_r.found, found);
        errors++;
      end
      if (offset !== exp_r.offset) begin
        $display("%0t: match_offset mismatch: expected %0d, actual %0d",
                 $time, exp_r.offset, offset);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } scan_item_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [mbps_pkg::CFG_INDEX_W-1:0]  cfg_index_i;
  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_data_i;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic [7:0]                        data_byte_i;
  logic                              last_byte_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic                              found_o;
  logic [mbps_pkg::RESULT_OFF_W-1:0] match_offset_o;

  scan_scoreboard sb = new();
  scan_item_t     item_q[$];
  int             item_total   = 0;
  int             burst_left   = 0;
  bit             steady_send  = 1'b1;
  bit             narrow_bytes = 1'b0;
  logic [7:0]     pat_b [mbps_pkg::PATTERN_MAX];
  logic [15:0]    care_bits;
  int             eff_len      = 0;
  int             stall_mode   = 0;
  int             stall_left   = 0;
  int             stall_cyc    = 0;

  masked_byte_pattern_search dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .match_offset_o (match_offset_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Result side: check accepted items, then pick the next stall value.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i)
      sb.check_result(found_o, match_offset_o);
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(50, 300);
    end else begin
      stall_left--;
    end
    stall_cyc++;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= ((stall_cyc % 11) < 6);
    endcase
  end

  function automatic logic [7:0] rand_byte();
    if (narrow_bytes) return $urandom_range(0, 1) ? 8'hA5 : 8'h5A;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void push_item(logic [7:0] data, logic last);
    scan_item_t it;
    it.data = data;
    it.last = last;
    item_q.push_back(it);
    item_total++;
  endfunction

  // Build one buffer: planted pattern (sometimes with a cared byte broken),
  // plain random bytes, or a buffer shorter than the pattern.
  function automatic void queue_buffer();
    int         kind;
    int         pre;
    int         j;
    logic [7:0] scan_bytes[$];
    kind = $urandom_range(0, 9);
    if (kind < 6 && eff_len > 0) begin
      pre = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 6);
      repeat (pre) scan_bytes.push_back(rand_byte());
      for (j = 0; j < eff_len; j++)
        scan_bytes.push_back(care_bits[j] ? pat_b[j] : rand_byte());
      if (kind >= 4) begin
        j = $urandom_range(0, eff_len - 1);
        scan_bytes[pre + j] = scan_bytes[pre + j] ^ 8'($urandom_range(1, 255));
      end
      repeat ($urandom_range(0, 4)) scan_bytes.push_back(rand_byte());
    end else if (kind < 8 || eff_len <= 1) begin
      repeat ($urandom_range(1, 24)) scan_bytes.push_back(rand_byte());
    end else begin
      repeat ($urandom_range(1, eff_len - 1)) scan_bytes.push_back(rand_byte());
    end
    foreach (scan_bytes[i]) push_item(scan_bytes[i], i == scan_bytes.size() - 1);
  endfunction

  function automatic int next_gap();
    if (steady_send) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 16);
    return $urandom_range(1, 5);
  endfunction

  // Drive queued items; valid stays up across a burst and drops in gaps.
  task automatic flush_items();
    scan_item_t it;
    int         gap;
    while (item_q.size() > 0) begin
      it = item_q.pop_front();
      in_valid_i  <= 1'b1;
      data_byte_i <= it.data;
      last_byte_i <= it.last;
      do @(posedge clk_i); while (in_stall_o !== 1'b0);
      sb.note_byte(it.data, it.last);
      gap = next_gap();
      if (item_q.size() == 0 || gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Hold until every expected result is back, then let the pipeline settle.
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(mbps_pkg::cfg_idx_e idx, logic [mbps_pkg::CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
  endtask

  task automatic program_config(logic [63:0] lo, logic [63:0] hi, logic [15:0] care,
                                logic [4:0] len, bit dirty);
    logic [63:0] junk;
    junk = dirty ? {$urandom, $urandom} : 64'd0;
    cfg_write(mbps_pkg::CFG_PATTERN_LOW, lo);
    cfg_write(mbps_pkg::CFG_PATTERN_HIGH, hi);
    cfg_write(mbps_pkg::CFG_CARE_MASK, {junk[63:16], care});
    cfg_write(mbps_pkg::CFG_PATTERN_LEN, {junk[63:5], len});
    cfg_we_i <= 1'b0;
    for (int j = 0; j < 8; j++) begin
      pat_b[j]     = lo[8*j +: 8];
      pat_b[j + 8] = hi[8*j +: 8];
    end
    care_bits = care;
    eff_len   = (len > mbps_pkg::PATTERN_MAX) ? mbps_pkg::PATTERN_MAX : int'(len);
  endtask

  task automatic random_config();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [15:0] care;
    logic [4:0]  len;
    int          sel;
    narrow_bytes = ($urandom_range(0, 3) == 0);
    steady_send  = ($urandom_range(0, 4) == 0);
    sel = $urandom_range(0, 9);
    if (sel == 0)     len = 5'd0;
    else if (sel == 1) len = 5'd16;
    else if (sel == 2) len = 5'($urandom_range(17, 31));
    else if (sel < 5)  len = 5'($urandom_range(9, 15));
    else               len = 5'($urandom_range(1, 8));
    sel = $urandom_range(0, 7);
    care = (sel == 0) ? 16'hFFFF : (sel == 1) ? 16'h0000 : 16'($urandom);
    sel = $urandom_range(0, 7);
    for (int j = 0; j < 8; j++) begin
      lo[8*j +: 8] = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : rand_byte();
      hi[8*j +: 8] = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : rand_byte();
    end
    program_config(lo, hi, care, len, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= mbps_pkg::CFG_PATTERN_LOW;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    data_byte_i <= 8'h00;
    last_byte_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: empty pattern matches at offset 0.
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b1);
    flush_items();
    wait_drained();

    // Four-byte pattern with wildcards and care bits set past the length.
    program_config(64'h0000_0000_EFBE_ADDE, 64'd0, 16'hFFF5, 5'd4, 1'b0);
    push_item(8'hDE, 1'b0);
    push_item(8'hAD, 1'b0);
    push_item(8'hBE, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'hDE, 1'b0);
    push_item(8'h77, 1'b0);
    push_item(8'hBE, 1'b0);
    push_item(8'h11, 1'b1);
    steady_send = 1'b0;
    flush_items();
    wait_drained();

    // Overlong length clamps to the full sixteen bytes.
    program_config(64'hFF00_FF00_00FF_00FF, 64'h00FF_FF00_0000_FFFF, 16'hFFFF,
                   5'd31, 1'b0);
    for (int j = 0; j < mbps_pkg::PATTERN_MAX; j++)
      push_item(pat_b[j], j == mbps_pkg::PATTERN_MAX - 1);
    flush_items();
    wait_drained();

    while (item_total < 950) begin
      random_config();
      repeat ($urandom_range(4, 10)) queue_buffer();
      flush_items();
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
